FILE: src/sgitlg_pkg.sv
// Shared types and constants for the SGI target-list grouper.
// Used by the front, queue, back and top-level modules; depends on nothing.
package sgitlg_pkg;

    // Default core count and queue depth
    localparam int CoreCountDefault = 32;
    localparam int QueueDepth       = 2;

    // Input item kinds
    localparam logic KIND_PUBLISH = 1'b0;
    localparam logic KIND_SEND    = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_SENT      = 2'd0;
    localparam logic [1:0] STATUS_PUBLISHED = 2'd1;
    localparam logic [1:0] STATUS_REFUSED   = 2'd2;

    // Configuration register indexes
    localparam logic CFG_SGI_NUMBER   = 1'b0;
    localparam logic CFG_RANGE_SELECT = 1'b1;

    // One classified item as it travels from front to back
    typedef struct packed {
        logic        kind;
        logic        refused;
        logic        store;
        logic [4:0]  core_index;
        logic [31:0] affinity;
        logic [31:0] core_mask;
    } t_entry;

endpackage

FILE: src/sgitlg_front.sv
// Front end: holds the configuration registers, accepts and classifies items.
// Depends on sgitlg_pkg.
module sgitlg_front import sgitlg_pkg::*; #(
    parameter int CORE_COUNT = CoreCountDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_kind,
    input  logic [4:0]  i_core_index,
    input  logic [31:0] i_affinity,
    input  logic [31:0] i_core_mask,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [3:0]  i_cfg_data,
    input  logic        i_q_full,
    output logic        o_busy,
    output logic        o_push,
    output t_entry      o_entry,
    output logic [3:0]  o_sgi_number
);

    logic [3:0] r_sgi_number;
    logic       r_rs_supported;
    logic       w_refused;
    logic       w_in_range;

    // Update configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sgi_number   <= '0;
            r_rs_supported <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SGI_NUMBER:   r_sgi_number   <= i_cfg_data;
                CFG_RANGE_SELECT: r_rs_supported <= i_cfg_data[0];
                default:          r_sgi_number   <= r_sgi_number;
            endcase
        end
    end

    // Classify: refuse a publish with a nonzero range select when it is unsupported
    assign w_refused  = (i_kind == KIND_PUBLISH) && (i_affinity[7:4] != 4'd0) &&
                        !r_rs_supported;
    assign w_in_range = {1'b0, i_core_index} < 6'(CORE_COUNT);

    always_comb begin
        o_entry.kind       = i_kind;
        o_entry.refused    = w_refused;
        o_entry.store      = (i_kind == KIND_PUBLISH) && !w_refused && w_in_range;
        o_entry.core_index = i_core_index;
        o_entry.affinity   = i_affinity;
        o_entry.core_mask  = i_core_mask;
    end

    // Accept a beat whenever the queue has room
    assign o_busy       = i_q_full;
    assign o_push       = i_start && !i_q_full;
    assign o_sgi_number = r_sgi_number;

endmodule

FILE: src/sgitlg_queue.sv
// Short FIFO of classified items between the front and back ends.
// Depends on sgitlg_pkg for the entry type.
module sgitlg_queue import sgitlg_pkg::*; #(
    parameter int DEPTH = QueueDepth
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_valid,
    output logic   o_full,
    output t_entry o_entry
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    t_entry            r_mem [DEPTH];
    logic [PtrW-1:0]   r_wr_ptr;
    logic [PtrW-1:0]   r_rd_ptr;
    logic [CntW-1:0]   r_count;

    // Store incoming beats
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CntW'(DEPTH));
    assign o_entry = r_mem[r_rd_ptr];

endmodule

FILE: src/sgitlg_back.sv
// Back end: affinity table, seated flags and the grouping sequencer.
// Depends on sgitlg_pkg; pops items from sgitlg_queue.
module sgitlg_back import sgitlg_pkg::*; #(
    parameter int CORE_COUNT = CoreCountDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_entry      i_q_entry,
    input  logic [3:0]  i_sgi_number,
    output logic        o_q_pop,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [63:0] o_sgi_word,
    output logic        o_last
);

    localparam int IdxW = (CORE_COUNT > 1) ? $clog2(CORE_COUNT) : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PICK  = 2'd1;
    localparam logic [1:0] ST_CHECK = 2'd2;

    logic [31:0]           r_table [CORE_COUNT];
    logic [31:0]           r_rd_data;
    logic [CORE_COUNT-1:0] r_seated;

    logic [1:0]            r_state,     n_state;
    logic [CORE_COUNT-1:0] r_pending,   n_pending;
    logic [CORE_COUNT-1:0] r_scan,      n_scan;
    logic [CORE_COUNT-1:0] r_cand_oh,   n_cand_oh;
    logic                  r_have_lead, n_have_lead;
    logic [23:0]           r_cluster,   n_cluster;
    logic [3:0]            r_rs,        n_rs;
    logic [15:0]           r_targets,   n_targets;
    logic                  r_valid,     n_valid;
    logic [1:0]            r_status,    n_status;
    logic [63:0]           r_word,      n_word;
    logic                  r_last,      n_last;

    logic [IdxW-1:0]       w_rd_addr;
    logic                  w_wr_en;
    logic [CORE_COUNT-1:0] w_lead_oh;
    logic [CORE_COUNT-1:0] w_scan_oh;
    logic [15:0]           w_bit;
    logic                  w_match;

    // Encode a one-hot core vector into its index
    function automatic logic [IdxW-1:0] f_index(input logic [CORE_COUNT-1:0] oh);
        logic [IdxW-1:0] idx;
        idx = '0;
        for (int i = 0; i < CORE_COUNT; i++) begin
            if (oh[i]) begin
                idx = idx | IdxW'(i);
            end
        end
        return idx;
    endfunction

    // Isolate the lowest pending core and the lowest core left to scan
    assign w_lead_oh = r_pending & (~r_pending + 1'b1);
    assign w_scan_oh = r_scan & (~r_scan + 1'b1);
    assign w_bit     = 16'd1 << r_rd_data[3:0];
    assign w_match   = (r_rd_data[31:8] == r_cluster) && (r_rd_data[7:4] == r_rs);

    // Sequence publish and send items
    always_comb begin
        n_state     = r_state;
        n_pending   = r_pending;
        n_scan      = r_scan;
        n_cand_oh   = r_cand_oh;
        n_have_lead = r_have_lead;
        n_cluster   = r_cluster;
        n_rs        = r_rs;
        n_targets   = r_targets;
        n_valid     = 1'b0;
        n_status    = r_status;
        n_word      = r_word;
        n_last      = r_last;
        w_rd_addr   = f_index(w_lead_oh);
        w_wr_en     = 1'b0;
        o_q_pop     = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (i_q_entry.kind == KIND_PUBLISH) begin
                        w_wr_en  = i_q_entry.store;
                        n_valid  = 1'b1;
                        n_status = i_q_entry.refused ? STATUS_REFUSED : STATUS_PUBLISHED;
                        n_word   = '0;
                        n_last   = 1'b1;
                    end else begin
                        n_pending = i_q_entry.core_mask[CORE_COUNT-1:0] & r_seated;
                        n_state   = ST_PICK;
                    end
                end
            end
            ST_PICK: begin
                // Take the lowest pending core as lead and fetch its affinity
                if (r_pending == '0) begin
                    n_state = ST_IDLE;
                end else begin
                    n_pending   = r_pending & ~w_lead_oh;
                    n_scan      = r_pending & ~w_lead_oh;
                    n_have_lead = 1'b0;
                    n_state     = ST_CHECK;
                end
            end
            ST_CHECK: begin
                // Latch the lead's key, or gather a matching candidate
                if (!r_have_lead) begin
                    n_cluster = r_rd_data[31:8];
                    n_rs      = r_rd_data[7:4];
                    n_targets = w_bit;
                end else if (w_match) begin
                    n_targets = r_targets | w_bit;
                    n_pending = r_pending & ~r_cand_oh;
                end
                n_have_lead = 1'b1;
                if (r_scan != '0) begin
                    w_rd_addr = f_index(w_scan_oh);
                    n_cand_oh = w_scan_oh;
                    n_scan    = r_scan & ~w_scan_oh;
                end else begin
                    n_valid  = 1'b1;
                    n_status = STATUS_SENT;
                    n_word   = {8'h00, n_cluster[23:16], n_rs, 4'h0, n_cluster[15:8],
                                4'h0, i_sgi_number, n_cluster[7:0], n_targets};
                    n_last   = (n_pending == '0);
                    n_state  = ST_PICK;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Write and read the affinity table
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_table[i_q_entry.core_index[IdxW-1:0]] <= i_q_entry.affinity;
        end
        r_rd_data <= r_table[w_rd_addr];
    end

    // Seat published cores
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seated <= '0;
        end else if (w_wr_en) begin
            r_seated[i_q_entry.core_index[IdxW-1:0]] <= 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pending <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pending <= n_pending;
            r_valid   <= n_valid;
        end
    end

    // Working and result payload registers
    always_ff @(posedge i_clk) begin
        r_scan      <= n_scan;
        r_cand_oh   <= n_cand_oh;
        r_have_lead <= n_have_lead;
        r_cluster   <= n_cluster;
        r_rs        <= n_rs;
        r_targets   <= n_targets;
        r_status    <= n_status;
        r_word      <= n_word;
        r_last      <= n_last;
    end

    assign o_valid    = r_valid;
    assign o_status   = r_status;
    assign o_sgi_word = r_word;
    assign o_last     = r_last;

    // No send work may be left over once the sequencer is idle
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_pending == '0))
        else $error("pending cores left while idle");

    // Publish results are single, final beats with an empty word
    a_publish_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != STATUS_SENT)) |-> (o_last && (o_sgi_word == 64'd0)))
        else $error("publish result not a lone zero beat");

    // Every word with sent status targets at least one core
    a_targets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == STATUS_SENT)) |-> (o_sgi_word[15:0] != 16'd0))
        else $error("emitted word has an empty target list");

    // A word that is not last leaves the sequencer picking the next group
    a_more_groups: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> (r_state == ST_PICK) && (r_pending != '0))
        else $error("non-final word with nothing left to send");

endmodule

FILE: src/sgi_target_list_grouper_unit.sv
// Top level of the SGI target-list grouper.
// Depends on sgitlg_pkg, sgitlg_front, sgitlg_queue and sgitlg_back.
//
// Publish items that are neither refused nor out of range seat a core and
// store its packed affinity; send items turn a core mask into SGI1R words,
// one per cluster and 16-wide Aff0 window, lowest lead core first, with
// o_last on the final word. A two-entry queue sits between the front end and
// the sequencer, so busy rises only while the queue holds two items. A send
// loads its mask of seated cores, then per group picks the lead and reads the
// affinity table once per pending core above the lead, and a closing pick
// with nothing pending returns the sequencer to idle. Results appear on
// o_valid for exactly one cycle and cannot be held off; a send that names no
// seated core produces no result.
module sgi_target_list_grouper_unit import sgitlg_pkg::*; #(
    parameter int CORE_COUNT = CoreCountDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_kind,
    input  logic [4:0]  i_core_index,
    input  logic [31:0] i_affinity,
    input  logic [31:0] i_core_mask,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [3:0]  i_cfg_data,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [63:0] o_sgi_word,
    output logic        o_last
);

    logic       w_push;
    logic       w_pop;
    logic       w_q_valid;
    logic       w_q_full;
    t_entry     w_in_entry;
    t_entry     w_q_entry;
    logic [3:0] w_sgi_number;

    sgitlg_front #(
        .CORE_COUNT (CORE_COUNT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_kind       (i_kind),
        .i_core_index (i_core_index),
        .i_affinity   (i_affinity),
        .i_core_mask  (i_core_mask),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_q_full     (w_q_full),
        .o_busy       (busy),
        .o_push       (w_push),
        .o_entry      (w_in_entry),
        .o_sgi_number (w_sgi_number)
    );

    sgitlg_queue #(
        .DEPTH (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_in_entry),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_full  (w_q_full),
        .o_entry (w_q_entry)
    );

    sgitlg_back #(
        .CORE_COUNT (CORE_COUNT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .i_q_entry    (w_q_entry),
        .i_sgi_number (w_sgi_number),
        .o_q_pop      (w_pop),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_sgi_word   (o_sgi_word),
        .o_last       (o_last)
    );

endmodule
